// ----- rtl/page_refcount_allocator_top_macros.svh -----
// Assertion macros used by the checker of this block.
// Both sample on clk; the first is switched off while rst is high.
`ifndef PAGE_REFCOUNT_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_REFCOUNT_ALLOCATOR_TOP_MACROS_SVH

`define PRCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define PRCA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/prca_pkg.sv -----
package prca_pkg;

  // defaults for the top level parameters
  localparam int NUM_PAGES_DEF  = 512;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int COUNT_BITS_DEF = 8;

  // fixed field widths
  localparam int FUNC_W    = 2;
  localparam int REQ_W     = 16;
  localparam int ADDR_W    = 21;
  localparam int STATUS_W  = 3;
  localparam int NCOUNT_W  = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 9'd256;
  localparam logic [CFG_W-1:0] LAST_PAGE_RST  = 9'd511;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST = 1'd0,
    REG_LAST  = 1'd1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_SHARE = 2'd2,
    FN_RSVD  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NONE_FREE = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_NOT_ALLOC = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LOOKUP,
    S_UPDATE,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    in_load;
    logic    clr_step;
    logic    scan_start;
    logic    scan_step;
    logic    grant_write;
    logic    upd_write;
    logic    res_load;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_free;
    logic is_rsvd;
    logic too_large;
    logic null_free;
    logic hit;
    logic scan_done;
    logic addr_bad;
    logic count_zero;
    logic count_max;
  } sts_t;

endpackage

// ----- rtl/prca_intf.sv -----
interface prca_in_if;
  logic                          valid;
  logic                          ready;
  logic [prca_pkg::FUNC_W-1:0]   func;
  logic [prca_pkg::REQ_W-1:0]    request_bytes;
  logic [prca_pkg::ADDR_W-1:0]   page_address;

  modport source (output valid, func, request_bytes, page_address, input ready);
  modport sink   (input valid, func, request_bytes, page_address, output ready);
  modport mon    (input valid, ready, func, request_bytes, page_address);
endinterface

interface prca_out_if;
  logic                          valid;
  logic                          ready;
  logic [prca_pkg::STATUS_W-1:0] status;
  logic [prca_pkg::ADDR_W-1:0]   granted_address;
  logic [prca_pkg::NCOUNT_W-1:0] new_count;

  modport source (output valid, status, granted_address, new_count, input ready);
  modport sink   (input valid, status, granted_address, new_count, output ready);
  modport mon    (input valid, ready, status, granted_address, new_count);
endinterface

// ----- rtl/prca_ram.sv -----
module prca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/prca_ctrl.sv -----
module prca_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  prca_pkg::sts_t   sts,
  output prca_pkg::cmd_t   cmd
);

  prca_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prca_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = prca_pkg::ST_OK;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;

    unique case (state)
      prca_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = prca_pkg::S_IDLE;
        end
      end

      prca_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = prca_pkg::S_DECODE;
        end
      end

      prca_pkg::S_DECODE: begin
        if (sts.is_alloc) begin
          if (sts.too_large) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = prca_pkg::ST_TOO_LARGE;
            state_next     = prca_pkg::S_RESULT;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = prca_pkg::S_SCAN;
          end
        end else if (sts.is_rsvd) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = prca_pkg::ST_BAD_ADDR;
          state_next     = prca_pkg::S_RESULT;
        end else if (sts.null_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = prca_pkg::ST_OK;
          state_next     = prca_pkg::S_RESULT;
        end else begin
          state_next = prca_pkg::S_LOOKUP;
        end
      end

      prca_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.grant_write = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = prca_pkg::ST_OK;
          state_next      = prca_pkg::S_RESULT;
        end else if (sts.scan_done) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = prca_pkg::ST_NONE_FREE;
          state_next     = prca_pkg::S_RESULT;
        end
      end

      // count read is issued here, data arrives in S_UPDATE
      prca_pkg::S_LOOKUP: begin
        if (sts.addr_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = prca_pkg::ST_BAD_ADDR;
          state_next     = prca_pkg::S_RESULT;
        end else begin
          state_next = prca_pkg::S_UPDATE;
        end
      end

      prca_pkg::S_UPDATE: begin
        cmd.res_load = 1'b1;
        state_next   = prca_pkg::S_RESULT;
        if (sts.count_zero) begin
          cmd.res_status = prca_pkg::ST_NOT_ALLOC;
        end else if (!sts.is_free && sts.count_max) begin
          cmd.res_status = prca_pkg::ST_SATURATED;
        end else begin
          cmd.upd_write  = 1'b1;
          cmd.res_status = prca_pkg::ST_OK;
        end
      end

      prca_pkg::S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = prca_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = prca_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/prca_datapath.sv -----
module prca_datapath #(
  parameter int NUM_PAGES  = prca_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = prca_pkg::PAGE_BYTES_DEF,
  parameter int COUNT_BITS = prca_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prca_pkg::CFG_W-1:0]        cfg_data,
  input  logic [prca_pkg::FUNC_W-1:0]       in_func,
  input  logic [prca_pkg::REQ_W-1:0]        in_request_bytes,
  input  logic [prca_pkg::ADDR_W-1:0]       in_page_address,
  input  prca_pkg::cmd_t                    cmd,
  output prca_pkg::sts_t                    sts,
  output logic [prca_pkg::STATUS_W-1:0]     out_status,
  output logic [prca_pkg::ADDR_W-1:0]       out_granted_address,
  output logic [prca_pkg::NCOUNT_W-1:0]     out_new_count
);

  localparam int AW  = prca_pkg::ADDR_W;
  localparam int NW  = prca_pkg::NCOUNT_W;
  localparam int PW  = $clog2(NUM_PAGES);
  localparam int SW  = $clog2(NUM_PAGES + 1);
  localparam int CW  = (PW > prca_pkg::CFG_W) ? PW : prca_pkg::CFG_W;
  localparam int OW  = $clog2(PAGE_BYTES);
  localparam int BW  = prca_pkg::REQ_W + 1;

  localparam logic [AW-1:0]         PAGE_STRIDE = AW'(PAGE_BYTES);
  localparam logic [AW-1:0]         OFF_MASK    = AW'(PAGE_BYTES - 1);
  localparam logic [SW-1:0]         PAGE_END    = SW'(NUM_PAGES);
  localparam logic [PW-1:0]         PAGE_TOP    = PW'(NUM_PAGES - 1);
  localparam logic [AW-1:0]         PAGE_LIMIT  = AW'(NUM_PAGES);
  localparam logic [BW-1:0]         BYTE_LIMIT  = BW'(PAGE_BYTES);
  localparam logic [COUNT_BITS-1:0] CNT_ONE     = COUNT_BITS'(1);
  localparam logic [NW-1:0]         OUT_ONE     = NW'(1);

  // configuration
  logic [prca_pkg::CFG_W-1:0] first_page, last_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= prca_pkg::FIRST_PAGE_RST;
      last_page  <= prca_pkg::LAST_PAGE_RST;
    end else if (cfg_we) begin
      unique case (prca_pkg::cfg_reg_t'(cfg_index))
        prca_pkg::REG_FIRST: first_page <= cfg_data;
        prca_pkg::REG_LAST:  last_page  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  prca_pkg::func_t             func;
  logic [prca_pkg::REQ_W-1:0]  req_bytes;
  logic [AW-1:0]               page_addr;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      func      <= prca_pkg::func_t'(in_func);
      req_bytes <= in_request_bytes;
      page_addr <= in_page_address;
    end
  end

  // count store
  logic                  ram_we;
  logic [PW-1:0]         ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  prca_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clearing pass
  logic [PW-1:0] clr_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_page <= '0;
    end else if (cmd.clr_step) begin
      clr_page <= clr_page + PW'(1);
    end
  end

  // first-fit scan, one read issued per cycle; chk_* tracks the read in flight
  logic [SW-1:0] scan_page;
  logic [AW-1:0] scan_addr;
  logic          chk_valid;
  logic [PW-1:0] chk_page;
  logic [AW-1:0] chk_addr;
  logic          scan_issue;
  logic          in_win;

  assign scan_issue = scan_page != PAGE_END;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_valid <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_page <= '0;
      scan_addr <= '0;
    end else if (cmd.scan_step && scan_issue) begin
      scan_page <= scan_page + SW'(1);
      scan_addr <= scan_addr + PAGE_STRIDE;
      chk_page  <= scan_page[PW-1:0];
      chk_addr  <= scan_addr;
    end
  end

  assign in_win = (CW'(chk_page) >= CW'(first_page)) && (CW'(chk_page) <= CW'(last_page));

  // page size is a power of two: page number and offset are plain address bits
  logic [AW-1:0] page_num;

  assign page_num = page_addr >> OW;

  // count update
  logic [COUNT_BITS-1:0]    nc_free, nc_share, nc_upd;
  logic [COUNT_BITS+NW-1:0] wide_free, wide_share, wide_max;

  assign nc_free    = ram_rdata - CNT_ONE;
  assign nc_share   = ram_rdata + CNT_ONE;
  assign nc_upd     = (func == prca_pkg::FN_FREE) ? nc_free : nc_share;
  assign wide_free  = {{NW{1'b0}}, nc_free};
  assign wide_share = {{NW{1'b0}}, nc_share};
  assign wide_max   = {{NW{1'b0}}, {COUNT_BITS{1'b1}}};

  always_comb begin
    ram_we    = cmd.clr_step || cmd.grant_write || cmd.upd_write;
    ram_raddr = cmd.scan_step ? scan_page[PW-1:0] : page_num[PW-1:0];
    if (cmd.clr_step) begin
      ram_waddr = clr_page;
      ram_wdata = '0;
    end else if (cmd.grant_write) begin
      ram_waddr = chk_page;
      ram_wdata = CNT_ONE;
    end else begin
      ram_waddr = page_num[PW-1:0];
      ram_wdata = nc_upd;
    end
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.clr_last   = clr_page == PAGE_TOP;
    sts.is_alloc   = func == prca_pkg::FN_ALLOC;
    sts.is_free    = func == prca_pkg::FN_FREE;
    sts.is_rsvd    = func == prca_pkg::FN_RSVD;
    sts.too_large  = {1'b0, req_bytes} > BYTE_LIMIT;
    sts.null_free  = (func == prca_pkg::FN_FREE) && (page_addr == '0);
    sts.hit        = chk_valid && in_win && (ram_rdata == '0);
    sts.scan_done  = !scan_issue && !chk_valid;
    sts.addr_bad   = ((page_addr & OFF_MASK) != '0) || (page_num >= PAGE_LIMIT);
    sts.count_zero = ram_rdata == '0;
    sts.count_max  = &ram_rdata;
  end

  // pending result, then the output register
  logic [prca_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0]                 res_addr;
  logic [NW-1:0]                 res_count;
  logic [NW-1:0]                 count_sel;
  logic                          ok_alloc;

  assign ok_alloc = (cmd.res_status == prca_pkg::ST_OK) && (func == prca_pkg::FN_ALLOC);

  always_comb begin
    count_sel = '0;
    case (cmd.res_status)
      prca_pkg::ST_OK: begin
        if (func == prca_pkg::FN_ALLOC) begin
          count_sel = OUT_ONE;
        end else if (func == prca_pkg::FN_FREE) begin
          count_sel = (page_addr == '0) ? '0 : wide_free[NW-1:0];
        end else begin
          count_sel = wide_share[NW-1:0];
        end
      end
      prca_pkg::ST_SATURATED: count_sel = wide_max[NW-1:0];
      default:                count_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_addr   <= ok_alloc ? chk_addr : '0;
      res_count  <= count_sel;
    end
    if (cmd.out_load) begin
      out_status          <= res_status;
      out_granted_address <= res_addr;
      out_new_count       <= res_count;
    end
  end

endmodule

// ----- rtl/page_refcount_allocator_top.sv -----
// Page reference-count allocator.
// Requests come in on req (func, request_bytes, page_address); one result per
// item leaves on rsp (status, granted_address, new_count). Both channels move
// an item when valid and ready are high at a rising edge of clk.
// After rst the count store is cleared one page a cycle, and req.ready stays
// low until the last page is cleared. Configuration writes on cfg_we are
// taken at any time, but should only be issued while the block is idle.
// One item is worked on at a time; req.ready is high only in the idle state,
// so a new item is taken at the earliest in the cycle after a result is
// loaded into the output register. Allocate: a first-fit scan issues one
// count read a cycle from page 0; a grant of page p shows on rsp after the
// scan reaches p, a failed scan after it has read every page, which sets the
// longest item time. Free and share take the page number straight from the
// address bits (page size a power of two) and read-modify-write the count.
// A bad address ends after lookup; too large, reserved and null free after decode.
// The result sits in an output register; if rsp.ready is low the next item is
// still accepted and worked on, and it waits for the output register at its end.
module page_refcount_allocator_top #(
  parameter int NUM_PAGES  = prca_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = prca_pkg::PAGE_BYTES_DEF,
  parameter int COUNT_BITS = prca_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [prca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prca_pkg::CFG_W-1:0]     cfg_data,
  prca_in_if.sink                        req,
  prca_out_if.source                     rsp
);

  prca_pkg::cmd_t cmd;
  prca_pkg::sts_t sts;

  prca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prca_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_func             (req.func),
    .in_request_bytes    (req.request_bytes),
    .in_page_address     (req.page_address),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_status          (rsp.status),
    .out_granted_address (rsp.granted_address),
    .out_new_count       (rsp.new_count)
  );

endmodule

// ----- rtl/prca_checker.sv -----
`include "page_refcount_allocator_top_macros.svh"

module prca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [prca_pkg::STATUS_W-1:0] rsp_status,
  input logic [prca_pkg::ADDR_W-1:0]   rsp_granted_address,
  input logic [prca_pkg::NCOUNT_W-1:0] rsp_new_count
);

  `PRCA_ASSERT(a_status_code, rsp_valid |-> rsp_status <= prca_pkg::ST_SATURATED, "status code out of range")

  `PRCA_ASSERT(a_fail_no_addr, rsp_valid && rsp_status != prca_pkg::ST_OK |-> rsp_granted_address == '0, "address given on a failed item")

  `PRCA_ASSERT(a_fail_no_count, rsp_valid && (rsp_status == prca_pkg::ST_TOO_LARGE || rsp_status == prca_pkg::ST_NONE_FREE || rsp_status == prca_pkg::ST_BAD_ADDR || rsp_status == prca_pkg::ST_NOT_ALLOC) |-> rsp_new_count == '0, "count given on a failed item")

  `PRCA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_granted_address) && $stable(rsp_new_count), "stalled result changed")

  `PRCA_ASSERT_RST(a_reset_quiet, rst |=> !req_ready && !rsp_valid, "channels active straight after reset")

endmodule

bind page_refcount_allocator_top prca_checker u_prca_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_granted_address (rsp.granted_address),
  .rsp_new_count       (rsp.new_count)
);
